// ----- rtl/ellr_pkg.sv -----
// ----------------------------------------------------------------------------
// ellr_pkg
// Shared types, widths and helpers for the ellipse-in-rectangle rasterizer.
// ----------------------------------------------------------------------------
package ellr_pkg;

    localparam int MAX_SIZE   = 32;
    localparam int RESULT_CAP = 64;

    localparam int IN_W    = 15;                   // box corner coordinates
    localparam int SIZE_W  = 6;                    // box width / height
    localparam int AXIS_W  = $clog2(MAX_SIZE);     // a = w-1, b = h-1
    localparam int SQ_W    = 2 * AXIS_W;           // a*a, b*b
    localparam int MUL_A_W = AXIS_W + 2;           // signed operand, holds 1-a
    localparam int PROD_W  = MUL_A_W + SQ_W + 1;
    localparam int STEP_W  = SQ_W + 3;             // 8*a*a, 8*b*b
    localparam int ERR_W   = 24;                   // ex, ey, err
    localparam int COORD_W = 16;
    localparam int CNT_W   = $clog2(RESULT_CAP);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8 * COORD_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQA    = 8'b0000_0010,
        ST_SQB    = 8'b0000_0100,
        ST_EXM    = 8'b0000_1000,
        ST_INIT   = 8'b0001_0000,
        ST_WALK_Y = 8'b0010_0000,
        ST_WALK_X = 8'b0100_0000,
        ST_TIP    = 8'b1000_0000
    } ellr_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic                      last;
    } ellr_group_t;

    // zero counts as one, oversize saturates
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SIZE)) begin
            r = SIZE_W'(MAX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/ellipse_rect_rasterizer.sv -----
// ----------------------------------------------------------------------------
// ellipse_rect_rasterizer
// Traces the ellipse inscribed in a box, four mirrored points per word.
// ----------------------------------------------------------------------------
//  channel | dir | ports                       | word
//  --------+-----+-----------------------------+------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata   | one box: corner and size
//  m_      | out | m_tvalid m_tready m_tdata   | four points; m_tlast on the
//          |     | m_tlast                     | final word of a box
//
//  Sequence: after its accept a box runs through setup (a*a, b*b, (1-a)*b*b
//  on the shared multiplier, then error init), then a y decision followed by
//  an x decision per quadrant-walk word, then the tip words, then idle again,
//  where the next box is taken.
//  s_tready is high only while the sequencer is idle; one box at a time.
//  A full output register stalls the sequencer in place, nothing is lost.
//  aresetn (synchronous, active low) clears the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module ellipse_rect_rasterizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // box_x[14:0], box_y[29:15], box_width[35:30], box_height[41:36], zero pad
    input  logic [ellr_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // p0_x[15:0], p0_y[31:16], p1_x[47:32], p1_y[63:48],
    // p2_x[79:64], p2_y[95:80], p3_x[111:96], p3_y[127:112]
    output logic [ellr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int IW = ellr_pkg::IN_W;
    localparam int SW = ellr_pkg::SIZE_W;

    logic                   core_idle;
    logic                   core_push;
    logic                   out_free;
    ellr_pkg::ellr_group_t  core_group;

    logic                               m_tvalid_reg;
    logic [ellr_pkg::M_TDATA_W-1:0]     m_tdata_reg;
    logic                               m_tlast_reg;

    // output register can take a word when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = core_idle;

    ellr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_tvalid && core_idle),
        .box_x      ($signed(s_tdata[IW-1:0])),
        .box_y      ($signed(s_tdata[2*IW-1:IW])),
        .box_width  (s_tdata[2*IW+SW-1:2*IW]),
        .box_height (s_tdata[2*IW+2*SW-1:2*IW+SW]),
        .out_free   (out_free),
        .idle       (core_idle),
        .push       (core_push),
        .group      (core_group)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (core_push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (core_push) begin
            m_tdata_reg <= {core_group.p3_y, core_group.p3_x,
                            core_group.p2_y, core_group.p2_x,
                            core_group.p1_y, core_group.p1_x,
                            core_group.p0_y, core_group.p0_x};
            m_tlast_reg <= core_group.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/ellr_mul.sv -----
// ----------------------------------------------------------------------------
// ellr_mul
// Shared small signed multiplier with registered product (setup squares).
// ----------------------------------------------------------------------------
module ellr_mul (
    input  logic                                 aclk,
    input  logic signed [ellr_pkg::MUL_A_W-1:0]  op_a,
    input  logic        [ellr_pkg::SQ_W-1:0]     op_b,
    output logic signed [ellr_pkg::PROD_W-1:0]   prod
);

    logic signed [ellr_pkg::PROD_W-1:0] prod_reg;
    logic signed [ellr_pkg::SQ_W:0]     op_b_s;

    assign op_b_s = $signed({1'b0, op_b});

    always_ff @(posedge aclk) begin
        prod_reg <= ellr_pkg::PROD_W'(op_a * op_b_s);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/ellr_core.sv -----
// ----------------------------------------------------------------------------
// ellr_core
// Sequencer and error-term datapath: setup squares, quadrant walk, tip run.
// ----------------------------------------------------------------------------
module ellr_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ellr_pkg::IN_W-1:0]    box_x,
    input  logic signed [ellr_pkg::IN_W-1:0]    box_y,
    input  logic        [ellr_pkg::SIZE_W-1:0]  box_width,
    input  logic        [ellr_pkg::SIZE_W-1:0]  box_height,
    input  logic                                out_free,
    output logic                                idle,
    output logic                                push,
    output ellr_pkg::ellr_group_t               group
);

    localparam int CW = ellr_pkg::COORD_W;
    localparam int EW = ellr_pkg::ERR_W;
    localparam logic [ellr_pkg::SIZE_W-1:0] SIZE_ONE = ellr_pkg::SIZE_W'(1);

    ellr_pkg::ellr_state_t state_reg, state_next;

    logic        [ellr_pkg::AXIS_W-1:0] a_reg, a_next;
    logic        [ellr_pkg::AXIS_W-1:0] b_reg, b_next;
    logic                               odd_reg, odd_next;
    logic        [ellr_pkg::SQ_W-1:0]   aa_reg, aa_next;
    logic        [ellr_pkg::SQ_W-1:0]   bb_reg, bb_next;
    logic signed [CW-1:0]               x0_reg, x0_next, x1_reg, x1_next;
    logic signed [CW-1:0]               y0_reg, y0_next, y1_reg, y1_next;
    logic signed [EW-1:0]               ex_reg, ex_next, ey_reg, ey_next;
    logic signed [EW-1:0]               err_reg, err_next;
    logic                               xa_reg, xa_next;
    logic        [ellr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    ellr_pkg::ellr_group_t              pend_reg, pend_next;

    logic signed [ellr_pkg::MUL_A_W-1:0] mul_a;
    logic        [ellr_pkg::SQ_W-1:0]    mul_b;
    logic signed [ellr_pkg::PROD_W-1:0]  prod;

    logic        [ellr_pkg::SIZE_W-1:0] w_c, h_c;
    logic                               odd_in;
    logic signed [CW-1:0]               px_c, py_c, y0_init;
    logic signed [EW-1:0]               stepa, stepb, aa_e, ex_init, ey_init;
    logic signed [EW:0]                 e2, ey_w, ex_w;
    logic signed [EW-1:0]               ey_up, ex_up;
    logic                               xstep;
    logic signed [CW:0]                 dx, dy, b_w;
    logic                               more_walk, more_tip, cap;

    ellr_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign w_c     = ellr_pkg::clamp_size(box_width);
    assign h_c     = ellr_pkg::clamp_size(box_height);
    // b = h-1 is odd when h is even
    assign odd_in  = ~h_c[0];
    assign px_c    = CW'(box_x);
    assign py_c    = CW'(box_y);
    // (b+1)/2 == h/2
    assign y0_init = py_c + $signed(CW'(h_c >> 1));

    assign stepa   = $signed(EW'({aa_reg, 3'b000}));
    assign stepb   = $signed(EW'({bb_reg, 3'b000}));
    assign aa_e    = $signed(EW'(aa_reg));
    assign ex_init = EW'(prod) <<< 2;
    assign ey_init = odd_reg ? (aa_e <<< 3) : (aa_e <<< 2);

    assign e2      = {err_reg, 1'b0};
    assign ey_w    = {ey_reg[EW-1], ey_reg};
    assign ex_w    = {ex_reg[EW-1], ex_reg};
    assign ey_up   = ey_reg + stepa;
    assign ex_up   = ex_reg + stepb;
    assign xstep   = xa_reg || (e2 > ey_w);

    assign dx        = (CW+1)'(x1_reg) - (CW+1)'(x0_reg);
    assign dy        = (CW+1)'(y0_reg) - (CW+1)'(y1_reg);
    assign b_w       = $signed((CW+1)'(b_reg));
    assign more_walk = xstep ? (dx >= (CW+1)'(2)) : (dx >= '0);
    assign cap       = (cnt_reg == '1);

    always_comb begin
        mul_a = $signed(ellr_pkg::MUL_A_W'(a_reg));
        mul_b = ellr_pkg::SQ_W'(a_reg);
        unique case (state_reg)
            ellr_pkg::ST_SQB: begin
                mul_a = $signed(ellr_pkg::MUL_A_W'(b_reg));
                mul_b = ellr_pkg::SQ_W'(b_reg);
            end
            ellr_pkg::ST_EXM: begin
                mul_a = ellr_pkg::MUL_A_W'(1) - $signed(ellr_pkg::MUL_A_W'(a_reg));
                mul_b = prod[ellr_pkg::SQ_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        odd_next   = odd_reg;
        aa_next    = aa_reg;
        bb_next    = bb_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        err_next   = err_reg;
        xa_next    = xa_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        push       = 1'b0;
        group      = pend_reg;
        more_tip   = dy < b_w;

        unique case (state_reg)
            ellr_pkg::ST_IDLE: begin
                if (start) begin
                    a_next     = ellr_pkg::AXIS_W'(w_c - SIZE_ONE);
                    b_next     = ellr_pkg::AXIS_W'(h_c - SIZE_ONE);
                    odd_next   = odd_in;
                    x0_next    = px_c;
                    x1_next    = px_c + $signed(CW'(w_c - SIZE_ONE));
                    y0_next    = y0_init;
                    y1_next    = y0_init - $signed(CW'(odd_in));
                    cnt_next   = '0;
                    state_next = ellr_pkg::ST_SQA;
                end
            end
            ellr_pkg::ST_SQA: begin
                state_next = ellr_pkg::ST_SQB;
            end
            ellr_pkg::ST_SQB: begin
                aa_next    = prod[ellr_pkg::SQ_W-1:0];
                state_next = ellr_pkg::ST_EXM;
            end
            ellr_pkg::ST_EXM: begin
                bb_next    = prod[ellr_pkg::SQ_W-1:0];
                state_next = ellr_pkg::ST_INIT;
            end
            ellr_pkg::ST_INIT: begin
                ex_next    = ex_init;
                ey_next    = ey_init;
                err_next   = ex_init + ey_init + (odd_reg ? aa_e : EW'(0));
                state_next = ellr_pkg::ST_WALK_Y;
            end
            ellr_pkg::ST_WALK_Y: begin
                pend_next = '{p0_x: x1_reg, p0_y: y0_reg, p1_x: x0_reg, p1_y: y0_reg,
                              p2_x: x0_reg, p2_y: y1_reg, p3_x: x1_reg, p3_y: y1_reg,
                              last: 1'b0};
                xa_next   = e2 >= ex_w;
                if (e2 <= ey_w) begin
                    y0_next  = y0_reg + CW'(1);
                    y1_next  = y1_reg - CW'(1);
                    ey_next  = ey_up;
                    err_next = err_reg + ey_up;
                end
                state_next = ellr_pkg::ST_WALK_X;
            end
            ellr_pkg::ST_WALK_X: begin
                group.last = cap || (!more_walk && !more_tip);
                if (out_free) begin
                    push     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (xstep) begin
                        x0_next  = x0_reg + CW'(1);
                        x1_next  = x1_reg - CW'(1);
                        ex_next  = ex_up;
                        err_next = err_reg + ex_up;
                    end
                    if (cap) begin
                        state_next = ellr_pkg::ST_IDLE;
                    end else if (more_walk) begin
                        state_next = ellr_pkg::ST_WALK_Y;
                    end else if (more_tip) begin
                        state_next = ellr_pkg::ST_TIP;
                    end else begin
                        state_next = ellr_pkg::ST_IDLE;
                    end
                end
            end
            ellr_pkg::ST_TIP: begin
                group = '{p0_x: x0_reg - CW'(1), p0_y: y0_reg,
                          p1_x: x1_reg + CW'(1), p1_y: y0_reg,
                          p2_x: x0_reg - CW'(1), p2_y: y1_reg,
                          p3_x: x1_reg + CW'(1), p3_y: y1_reg,
                          last: 1'b0};
                // next test after this row: y0-y1 grows by two
                more_tip   = (dy + (CW+1)'(2)) < b_w;
                group.last = cap || !more_tip;
                if (out_free) begin
                    push     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    y0_next  = y0_reg + CW'(1);
                    y1_next  = y1_reg - CW'(1);
                    if (group.last) begin
                        state_next = ellr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ellr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ellr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        odd_reg  <= odd_next;
        aa_reg   <= aa_next;
        bb_reg   <= bb_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        err_reg  <= err_next;
        xa_reg   <= xa_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
    end

    assign idle = (state_reg == ellr_pkg::ST_IDLE);

endmodule

// ----- rtl/ellr_checker.sv -----
// ----------------------------------------------------------------------------
// ellr_checker
// Port-level checks for the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module ellr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ellr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    // stalled word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("m_ word changed under stall");

    // one box at a time: busy right after accepting a box
    a_s_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after accept");

    // a pending non-final word means the box is still being traced
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a run");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind ellipse_rect_rasterizer ellr_checker u_ellr_checker (.*);
